FILE: sv/median_of_set_assert.svh
// Assertion macros shared by the median_of_set RTL files.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MEDIAN_OF_SET_ASSERT_SVH
`define MEDIAN_OF_SET_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MOS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define MOS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define MOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mos_pkg.sv
// Shared types and constants for the median_of_set block.
// No dependencies; used by mos_sorter and median_of_set.
package mos_pkg;

    // Store capacity and derived widths.
    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int DATA_W      = 32;
    localparam int OUT_CNT_W   = 7;

    // Sorter sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_LAST,
        S_MED_HI,
        S_MED_LO
    } sort_state_t;

    // Top-level control states.
    typedef enum logic [1:0] {
        T_IDLE,
        T_INSERT,
        T_MEDIAN,
        T_OUTPUT
    } top_state_t;

    // Command from the control FSM to the sorter.
    typedef struct packed {
        logic                      ins;
        logic                      med;
        logic signed [DATA_W-1:0]  value;
        logic [CNT_W-1:0]          count;
    } sort_cmd_t;

    // Status from the sorter back to the control FSM.
    typedef struct packed {
        logic                      done;
        logic signed [DATA_W-1:0]  median;
    } sort_stat_t;

endpackage

FILE: sv/median_of_set.sv
// median_of_set: streams a set of signed samples and returns its median.
// One request on the sample channel carries one sample; last_sample marks
// the end of a set. After the last sample one request leaves on the result
// channel with the median, the number of kept samples and a drop flag.
// Each sample is inserted into a sorted store of MAX_SAMPLES entries with
// one read and one write port, one entry examined per cycle, so a sample
// keeps sample_stall high after acceptance for longer the more larger
// samples it passes. A last sample then adds the median reads and the
// load of the result register. A sample that arrives with the store full
// is dropped at once and sets samples_dropped.
// Reset clears the control state and empties the set; the store contents
// need no clearing since only entries below the count are read.
// The result sits in an output register: while result_stall is high it
// holds, and the block keeps accepting samples of the next set; after that
// set's last sample has been processed, sample_stall stays high until the
// held result has been taken.
// Depends on mos_pkg, mos_sorter and median_of_set_assert.svh.
`include "median_of_set_assert.svh"

module median_of_set (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic signed [mos_pkg::DATA_W-1:0]  sample_value,
    input  logic                               last_sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [mos_pkg::DATA_W-1:0]  median_value,
    output logic [mos_pkg::OUT_CNT_W-1:0]      sample_count,
    output logic                               samples_dropped
);
    import mos_pkg::*;

    top_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         held_reg, held_next;
    logic                     overflow_reg, overflow_next;
    logic                     last_reg, last_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_median_reg, out_median_next;
    logic [OUT_CNT_W-1:0]     out_count_reg, out_count_next;
    logic                     out_drop_reg, out_drop_next;

    logic                     accept;
    logic                     out_free;
    sort_cmd_t                cmd;
    sort_stat_t               stat;

    mos_sorter u_sorter (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign sample_stall = (state_reg != T_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !out_valid_reg || !result_stall;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            held_reg      <= '0;
            overflow_reg  <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            overflow_reg  <= overflow_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        out_median_reg <= out_median_next;
        out_count_reg  <= out_count_next;
        out_drop_reg   <= out_drop_next;
    end

    // Sequencing of insert, median and result load.
    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        overflow_next   = overflow_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_median_next = out_median_reg;
        out_count_next  = out_count_reg;
        out_drop_next   = out_drop_reg;
        cmd.ins         = 1'b0;
        cmd.med         = 1'b0;
        cmd.value       = sample_value;
        cmd.count       = held_reg;

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (held_reg < CNT_W'(MAX_SAMPLES))
                    begin
                        cmd.ins    = 1'b1;
                        held_next  = held_reg + 1'b1;
                        last_next  = last_sample;
                        state_next = T_INSERT;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                        if (last_sample)
                        begin
                            cmd.med    = 1'b1;
                            state_next = T_MEDIAN;
                        end
                    end
                end
            end

            T_INSERT:
            begin
                if (stat.done)
                begin
                    if (last_reg)
                    begin
                        cmd.med    = 1'b1;
                        state_next = T_MEDIAN;
                    end
                    else
                    begin
                        state_next = T_IDLE;
                    end
                end
            end

            T_MEDIAN:
            begin
                if (stat.done)
                begin
                    state_next = T_OUTPUT;
                end
            end

            T_OUTPUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_median_next = stat.median;
                    out_count_next  = OUT_CNT_W'(held_reg);
                    out_drop_next   = overflow_reg;
                    held_next       = '0;
                    overflow_next   = 1'b0;
                    state_next      = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign result_valid    = out_valid_reg;
    assign median_value    = out_median_reg;
    assign sample_count    = out_count_reg;
    assign samples_dropped = out_drop_reg;

    `MOS_ASSERT_ALWAYS(a_held_cap, held_reg <= CNT_W'(MAX_SAMPLES), "held count above capacity")
    `MOS_ASSERT_IMPLY(a_done_state, stat.done,
        state_reg == T_INSERT || state_reg == T_MEDIAN, "sorter done outside a wait state")
    `MOS_ASSERT_IMPLY(a_median_nonempty, cmd.med, held_reg != '0, "median of an empty set")
    `MOS_ASSERT_NEXT(a_load_clears, state_reg == T_OUTPUT && out_free,
        held_reg == '0 && !overflow_reg && out_valid_reg, "result load did not reset the set")

endmodule

FILE: sv/mos_sorter.sv
// Sorted sample store with an insertion sequencer and median readout.
// Depends on mos_pkg and median_of_set_assert.svh.
`include "median_of_set_assert.svh"

module mos_sorter (
    input  logic               clk,
    input  logic               rst_n,
    input  mos_pkg::sort_cmd_t cmd,
    output mos_pkg::sort_stat_t stat
);
    import mos_pkg::*;

    logic signed [DATA_W-1:0] mem [MAX_SAMPLES];

    sort_state_t              state_reg, state_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic signed [DATA_W-1:0] hi_reg, hi_next;
    logic signed [DATA_W-1:0] median_reg, median_next;
    logic                     odd_reg, odd_next;
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [CNT_W-1:0]         mid;
    logic signed [DATA_W:0]   pair_sum;

    // Store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer state and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        hi_reg     <= hi_next;
        median_reg <= median_next;
        odd_reg    <= odd_next;
    end

    assign mid      = cmd.count >> 1;
    assign pair_sum = {hi_reg[DATA_W-1], hi_reg} + {rd_data_reg[DATA_W-1], rd_data_reg};

    // Insertion walks down from the top, shifting larger entries up one place
    // while the next lower entry is already being read.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        value_next  = value_reg;
        hi_next     = hi_reg;
        median_next = median_reg;
        odd_next    = odd_reg;
        done_next   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = value_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.ins)
                begin
                    value_next = cmd.value;
                    if (cmd.count == '0)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_data   = cmd.value;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(cmd.count - 1'b1);
                        idx_next   = ADDR_W'(cmd.count);
                        state_next = S_INS_CMP;
                    end
                end
                else if (cmd.med)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(mid);
                    idx_next   = ADDR_W'(mid);
                    odd_next   = cmd.count[0];
                    state_next = S_MED_HI;
                end
            end

            S_INS_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data_reg > value_reg)
                begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == ADDR_W'(1))
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_INS_LAST:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_MED_HI:
            begin
                if (odd_reg)
                begin
                    median_next = rd_data_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    hi_next    = rd_data_reg;
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg - 1'b1;
                    state_next = S_MED_LO;
                end
            end

            S_MED_LO:
            begin
                // Floor halving of the 33-bit sum.
                median_next = pair_sum[DATA_W:1];
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stat.done   = done_reg;
    assign stat.median = median_reg;

    `MOS_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "sorter done held for two cycles")
    `MOS_ASSERT_IMPLY(a_cmp_idx, state_reg == S_INS_CMP, idx_reg != '0,
        "insertion compare at bottom of store")
    `MOS_ASSERT_IMPLY(a_cmd_excl, cmd.ins, !cmd.med, "insert and median requested together")
    `MOS_ASSERT_IMPLY(a_cmd_idle, cmd.ins || cmd.med, state_reg == S_IDLE,
        "sorter command while busy")

endmodule
